/* rtl/core/spi_command_framer_assert.svh */
// Assertion macros shared by the framer checker.
`ifndef SPI_COMMAND_FRAMER_ASSERT_SVH
`define SPI_COMMAND_FRAMER_ASSERT_SVH

// Same-cycle property, sampled on the rising clock, off during reset.
`define SCF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer check failed (same cycle)");

// Next-cycle property, sampled on the rising clock, off during reset.
`define SCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer check failed (next cycle)");

`endif

/* rtl/core/scf_pkg.sv */
// Package of the SPI command framer: opcode table, widths and shared types.
package scf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 7;

  // Opcodes with a payload other than one byte.
  localparam logic [ByteW-1:0] OpU = 8'h75;
  localparam logic [ByteW-1:0] OpV = 8'h76;
  localparam logic [ByteW-1:0] OpS = 8'h73;
  localparam logic [ByteW-1:0] OpK = 8'h6B;
  localparam logic [ByteW-1:0] OpC = 8'h63;
  localparam logic [ByteW-1:0] OpT = 8'h74;
  localparam logic [ByteW-1:0] OpB = 8'h62;

  localparam logic [IdxW-1:0] LenDefault = 7'd1;
  localparam logic [IdxW-1:0] LenU       = 7'd3;
  localparam logic [IdxW-1:0] LenV       = 7'd4;
  localparam logic [IdxW-1:0] LenSkc     = 7'd5;
  localparam logic [IdxW-1:0] LenT       = 7'd6;
  localparam logic [IdxW-1:0] LenB       = 7'd65;

  typedef struct packed {
    logic [IdxW-1:0]  bytes_seen;
    logic [IdxW-1:0]  expected_last;
    logic [ByteW-1:0] held_opcode;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0] reply_byte;
    logic [IdxW-1:0]  byte_index;
    logic             frame_done;
    logic [IdxW-1:0]  payload_length;
    logic [ByteW-1:0] opcode;
  } result_t;

  // Payload length that follows an opcode; unknown codes take one byte.
  function automatic logic [IdxW-1:0] payload_for(logic [ByteW-1:0] op);
    logic [IdxW-1:0] len;
    case (op) inside
      OpU:           len = LenU;
      OpV:           len = LenV;
      OpS, OpK, OpC: len = LenSkc;
      OpT:           len = LenT;
      OpB:           len = LenB;
      default:       len = LenDefault;
    endcase
    return len;
  endfunction

endpackage

/* rtl/core/scf_frame_step.sv */
// Per-byte framing logic: result fields and next framer state for one item.
module scf_frame_step (
  input  logic [scf_pkg::ByteW-1:0] rx_byte_i,
  input  scf_pkg::state_t           state_i,
  output scf_pkg::state_t           state_o,
  output scf_pkg::result_t          result_o
);

  logic [scf_pkg::IdxW-1:0]  idx;
  logic [scf_pkg::IdxW-1:0]  exp_last;
  logic [scf_pkg::ByteW-1:0] op;
  logic                      done;

  always_comb begin
    idx = state_i.bytes_seen;
    // Latch opcode and its length on the first byte of a message.
    if (idx == '0) begin
      op       = rx_byte_i;
      exp_last = scf_pkg::payload_for(rx_byte_i);
    end else begin
      op       = state_i.held_opcode;
      exp_last = state_i.expected_last;
    end
    done = (idx == exp_last);

    state_o.held_opcode   = op;
    state_o.expected_last = exp_last;
    state_o.bytes_seen    = done ? '0 : scf_pkg::IdxW'(idx + 1'b1);

    result_o.reply_byte     = done ? op : rx_byte_i;
    result_o.byte_index     = idx;
    result_o.frame_done     = done;
    result_o.payload_length = done ? idx : '0;
    result_o.opcode         = op;
  end

endmodule

/* rtl/core/spi_command_framer.sv */
// Top level of the SPI command framer: input register, framing step, result register.
//
// The framer takes one received SPI byte per item and returns one result item per
// byte. The first byte of a message is an opcode; a fixed table gives how many bytes
// follow it (u: 3, v: 4, s/k/c: 5, t: 6, b: 65, every other code: 1). Each result
// carries the byte's index in its message (opcode at 0), the current opcode, and a
// reply byte that echoes the received byte. On the last byte of a message frame_done
// is high, payload_length gives the number of bytes after the opcode, the reply byte
// is the opcode, and the framer rearms so the next byte starts a new message.
// Throughput is one item per cycle while no held result stalls the input. A byte
// waits in the input register until it can move on; its result item is then loaded into
// the result register and shown on the outputs. The framing state advances as
// an item moves from the input register into the result register. A held result
// stalls the input only once the input register is also full, so up to two items
// can be waiting inside while the receiver holds off.
module spi_command_framer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [scf_pkg::ByteW-1:0] rx_byte_i,
  // Result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [scf_pkg::ByteW-1:0] reply_byte_o,
  output logic [scf_pkg::IdxW-1:0]  byte_index_o,
  output logic                      frame_done_o,
  output logic [scf_pkg::IdxW-1:0]  payload_length_o,
  output logic [scf_pkg::ByteW-1:0] opcode_o
);

  // Input register
  logic                      in_valid_q, in_valid_d;
  logic [scf_pkg::ByteW-1:0] rx_q;

  // Framing state
  scf_pkg::state_t state_q, state_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  scf_pkg::result_t res_q, res_d;

  logic in_accept;
  logic advance;

  // Move an item forward when the result register is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  scf_frame_step u_step (
    .rx_byte_i (rx_q),
    .state_i   (state_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      // Advance the framer exactly once per item, in order.
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers: hold while stalled, load on transfer.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rx_q <= rx_byte_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reply_byte_o     = res_q.reply_byte;
  assign byte_index_o     = res_q.byte_index;
  assign frame_done_o     = res_q.frame_done;
  assign payload_length_o = res_q.payload_length;
  assign opcode_o         = res_q.opcode;

endmodule

/* rtl/core/scf_checker.sv */
// Port-level checker of the SPI command framer and its bind.
`include "spi_command_framer_assert.svh"

module scf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [scf_pkg::ByteW-1:0] reply_byte_o,
  input logic [scf_pkg::IdxW-1:0]  byte_index_o,
  input logic                      frame_done_o,
  input logic [scf_pkg::IdxW-1:0]  payload_length_o,
  input logic [scf_pkg::ByteW-1:0] opcode_o
);

  // A stalled result item stays valid and keeps its fields.
  `SCF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(reply_byte_o) && $stable(byte_index_o)
                   && $stable(frame_done_o) && $stable(payload_length_o)
                   && $stable(opcode_o))

  // The last byte reports its own index as the payload length and replies with the opcode.
  `SCF_ASSERT_NOW(a_done_fields, out_valid_o && frame_done_o,
                  payload_length_o == byte_index_o && reply_byte_o == opcode_o)

  // Mid-message bytes carry no length.
  `SCF_ASSERT_NOW(a_not_done_len, out_valid_o && !frame_done_o, payload_length_o == '0)

  // An opcode byte never completes a message.
  `SCF_ASSERT_NOW(a_opcode_not_last, out_valid_o && byte_index_o == '0, !frame_done_o)

  // The input stalls only behind a held result item.
  `SCF_ASSERT_NOW(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind spi_command_framer scf_checker u_scf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .reply_byte_o     (reply_byte_o),
  .byte_index_o     (byte_index_o),
  .frame_done_o     (frame_done_o),
  .payload_length_o (payload_length_o),
  .opcode_o         (opcode_o)
);
